// ----- rtl/box_child_search_defines.svh -----
// assertion macros shared by the box child search checker
`ifndef BOX_CHILD_SEARCH_DEFINES_SVH
`define BOX_CHILD_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bcs_pkg.sv -----
// shared types and constants of the box child search block
package bcs_pkg;

    // box limit per search and widths that follow from it
    localparam int unsigned MAX_BOXES = 256;
    localparam int unsigned COUNT_W   = $clog2(MAX_BOXES + 1);

    // header lengths in bytes
    localparam int unsigned HDR_SHORT = 8;
    localparam int unsigned HDR_LONG  = 16;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WANT_TYPE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SIZE  = 8'd3;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    // configuration as seen by the search core
    typedef struct packed {
        logic [31:0] want_type;
        logic [63:0] region_start;
        logic [63:0] region_end;
        logic [63:0] source_size;
    } cfg_t;

    // one result from the search core
    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [63:0] payload_start;
        logic [63:0] payload_end;
    } res_t;

endpackage

// ----- rtl/box_child_search.sv -----
// top level of the box child search block: config registers and stream stages
//
// channel   direction  transaction                      payload
// s_*       in         start command or one region byte  tuser command, tdata data_byte
// m_*       out        one search result                 tuser status, tdata payload bounds
// cfg_*     in         one register write                cfg_index, cfg_data
//
// one item per cycle sustained while m_tready is high; an item is registered on entry,
// processed by the search core once the output register is free, and its result,
// if any, lands in the output register
// m_tready low holds the output register; s_tready then stays high until the input
// register also holds an item
// reset clears search state, config and valid flags; writes are accepted every cycle
module box_child_search (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,    // data_byte
    input  logic [0:0]                         s_tuser,    // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [127:0]                       m_tdata,    // payload_start, payload_end
    output logic [1:0]                         m_tuser,    // status
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                        cfg_data
);

    bcs_pkg::cfg_t cfg;
    bcs_pkg::res_t res;

    logic [31:0] want_type_reg;
    logic [63:0] region_start_reg;
    logic [63:0] region_end_reg;
    logic [63:0] source_size_reg;

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;

    // output stage
    logic             out_valid_reg, out_valid_next;
    bcs_pkg::status_t out_status_reg;
    logic [63:0]      out_ps_reg;
    logic [63:0]      out_pe_reg;

    logic s_fire;
    logic out_free;
    logic proc;

    // config writes are never stalled
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_type_reg    <= 32'd0;
            region_start_reg <= 64'd0;
            region_end_reg   <= 64'd0;
            source_size_reg  <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bcs_pkg::CFG_WANT_TYPE:    want_type_reg    <= cfg_data[31:0];
                bcs_pkg::CFG_REGION_START: region_start_reg <= cfg_data;
                bcs_pkg::CFG_REGION_END:   region_end_reg   <= cfg_data;
                bcs_pkg::CFG_SOURCE_SIZE:  source_size_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.want_type    = want_type_reg;
    assign cfg.region_start = region_start_reg;
    assign cfg.region_end   = region_end_reg;
    assign cfg.source_size  = source_size_reg;

    // the held item moves on when the output register is empty or draining
    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || proc;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_cmd_reg  <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    bcs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc),
        .command   (in_cmd_reg),
        .data_byte (in_byte_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // result register, reloaded only when a result comes out
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc && res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && res.valid)
        begin
            out_status_reg <= res.status;
            out_ps_reg     <= res.payload_start;
            out_pe_reg     <= res.payload_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_pe_reg, out_ps_reg};

endmodule

// ----- rtl/bcs_core.sv -----
// search state and per-item header parsing, judging and skipping
module bcs_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic            command,
    input  logic [7:0]      data_byte,
    input  bcs_pkg::cfg_t   cfg,
    output bcs_pkg::res_t   res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_SKIP   = 3'b100
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [63:0]                   pos_reg, pos_next;
    logic [3:0]                    hidx_reg, hidx_next;
    logic [63:0]                   bsize_reg, bsize_next;
    logic [31:0]                   btype_reg, btype_next;
    logic [63:0]                   skip_reg, skip_next;
    logic [bcs_pkg::COUNT_W-1:0]   count_reg, count_next;

    logic [3:0]  hidx_inc;
    logic [63:0] size_sh;
    logic [31:0] type_sh;
    logic        hl16;
    logic [63:0] hl_ext;
    logic [63:0] room;          // region_end - position
    logic [63:0] srem;          // bytes of source past position
    logic [63:0] jsize;
    logic        end_small;
    logic [63:0] end_lim;       // last offset where a short header still fits
    logic [63:0] adv_size;
    logic [63:0] adv_pos;
    logic        adv_fail;
    logic        start_fail;
    logic        go_begin;
    logic        go_fail;

    // header byte shifting
    assign hidx_inc = hidx_reg + 4'd1;

    always_comb
    begin
        if (hidx_reg < 4'd4)
        begin
            size_sh = {32'd0, bsize_reg[23:0], data_byte};
        end
        else if (hidx_reg < 4'd8)
        begin
            size_sh = bsize_reg;
        end
        else
        begin
            size_sh = {bsize_reg[55:0], data_byte};
        end
    end

    assign type_sh = (hidx_reg >= 4'd4 && hidx_reg < 4'd8) ? {btype_reg[23:0], data_byte}
                                                           : btype_reg;

    // long header is judged when the index wraps
    assign hl16   = (hidx_inc == 4'd0);
    assign hl_ext = hl16 ? 64'(bcs_pkg::HDR_LONG) : 64'(bcs_pkg::HDR_SHORT);

    // bounds taken from the live settings and the current position
    assign room  = cfg.region_end - pos_reg;
    assign srem  = (cfg.source_size > pos_reg) ? (cfg.source_size - pos_reg) : 64'd0;
    assign jsize = (!hl16 && size_sh == 64'd0) ? srem : size_sh;

    // no header fits once the position is past region_end - 8
    assign end_small = (cfg.region_end < 64'(bcs_pkg::HDR_SHORT));
    assign end_lim   = cfg.region_end - 64'(bcs_pkg::HDR_SHORT);

    // advance to the next box
    assign adv_size = (phase_reg == PH_SKIP) ? bsize_reg : jsize;
    assign adv_pos  = pos_reg + adv_size;
    assign adv_fail = end_small || (adv_pos > end_lim)
                   || (count_reg >= bcs_pkg::COUNT_W'(bcs_pkg::MAX_BOXES));

    // start of a search
    assign start_fail = end_small || (cfg.region_start > end_lim);

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        hidx_next   = hidx_reg;
        bsize_next  = bsize_reg;
        btype_next  = btype_reg;
        skip_next   = skip_reg;
        count_next  = count_reg;
        res         = '0;
        go_begin    = 1'b0;
        go_fail     = 1'b0;

        if (fire)
        begin
            if (command == bcs_pkg::CMD_START)
            begin
                pos_next   = cfg.region_start;
                count_next = '0;
                skip_next  = 64'd0;
                go_begin   = 1'b1;
                go_fail    = start_fail;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        bsize_next = size_sh;
                        btype_next = type_sh;
                        hidx_next  = hidx_inc;
                        if (hidx_inc == 4'd8 && size_sh == 64'd1)
                        begin
                            // extended size follows
                            bsize_next  = 64'd0;
                        end
                        else if (hidx_inc == 4'd8 || hidx_inc == 4'd0)
                        begin
                            bsize_next  = jsize;
                            if (jsize < hl_ext || jsize > room)
                            begin
                                res.valid  = 1'b1;
                                res.status = bcs_pkg::ST_MALFORMED;
                                phase_next = PH_IDLE;
                            end
                            else if (type_sh == cfg.want_type)
                            begin
                                res.valid         = 1'b1;
                                res.status        = bcs_pkg::ST_FOUND;
                                res.payload_start = pos_reg + hl_ext;
                                res.payload_end   = adv_pos;
                                phase_next        = PH_IDLE;
                            end
                            else if (jsize == hl_ext)
                            begin
                                // empty payload, next box right away
                                pos_next  = adv_pos;
                                go_begin  = 1'b1;
                                go_fail   = adv_fail;
                            end
                            else
                            begin
                                skip_next  = jsize - hl_ext;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 64'd1;
                        if (skip_reg == 64'd1)
                        begin
                            pos_next  = adv_pos;
                            go_begin  = 1'b1;
                            go_fail   = adv_fail;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (go_begin)
            begin
                if (go_fail)
                begin
                    res.valid  = 1'b1;
                    res.status = bcs_pkg::ST_NOT_FOUND;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    count_next  = count_next + 1'b1;
                    phase_next  = PH_HEADER;
                    hidx_next   = 4'd0;
                    bsize_next  = 64'd0;
                    btype_next  = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= 64'd0;
            hidx_reg   <= 4'd0;
            bsize_reg  <= 64'd0;
            btype_reg  <= 32'd0;
            skip_reg   <= 64'd0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            hidx_reg   <= hidx_next;
            bsize_reg  <= bsize_next;
            btype_reg  <= btype_next;
            skip_reg   <= skip_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/bcs_checker.sv -----
// port-level checks of the box child search block, bound to the top level
`include "box_child_search_defines.svh"

module bcs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser
);

    logic         fail_out;
    logic         found_out;
    logic         held_out;
    logic         bounds_ok;
    logic [129:0] out_word;

    assign fail_out  = m_tvalid && (m_tuser != bcs_pkg::ST_FOUND);
    assign found_out = m_tvalid && (m_tuser == bcs_pkg::ST_FOUND);
    assign held_out  = m_tvalid && !m_tready;
    assign bounds_ok = (m_tdata[63:0] <= m_tdata[127:64]);
    assign out_word  = {m_tuser, m_tdata};

    // an empty output stage always leaves room for a new item
    `BCS_ASSERT_IMP(a_ready_when_out_empty, !m_tvalid, s_tready, "input stalled with empty output")

    // failures carry zero bounds
    `BCS_ASSERT_IMP(a_zero_bounds, fail_out, m_tdata == 128'd0, "nonzero bounds on failure")

    // a found payload never starts past its end
    `BCS_ASSERT_IMP(a_bounds_order, found_out, bounds_ok, "payload start past end")

    // a stalled result holds
    `BCS_ASSERT_NXT(a_out_hold, held_out, m_tvalid && $stable(out_word), "stalled result moved")

endmodule

bind box_child_search bcs_checker u_bcs_checker (.*);
